[rtl/rxbb_pkg.sv]
// Shared types, constants and the CRC-16/MODBUS byte update for the receive byte buffer.
package rxbb_pkg;

    typedef enum logic [1:0] {
        OP_RECEIVE = 2'd0,
        OP_READ    = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_RESTART = 2'd3
    } op_t;

    localparam int          CRC_W    = 16;
    localparam int          HIST_N   = 4;
    localparam int          COUNT_OW = 9;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef logic [CRC_W-1:0] crc_t;

    // Reflected CRC-16, one byte, bit by bit.
    function automatic crc_t crc16_byte(input crc_t crc, input logic [7:0] b);
        crc_t c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[rtl/rxbb_store.sv]
// Byte store memory: one write port, one read port with registered read data.
module rxbb_store
    import rxbb_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/rx_byte_buffer_with_crc16_history_top.sv]
// Receive byte buffer with running CRC-16/MODBUS and four-deep CRC history.
//
// Usage:
//   Input channel s_*: one operation per transfer (receive byte, read entry,
//   clear store and count, restart CRC). Result channel m_*: one result per
//   input transfer, in order, carrying the CRC, its history, the count, the
//   wrapped flag and the read byte.
//   The result is registered: it is valid in the cycle after the input transfer.
//   Throughput: one item per cycle; s_ready is high whenever the result
//   register is empty or being taken in the same cycle, set by the single
//   result register and the registered read of the store memory.
//   Entries not written since the last clear read as zero: an entry is live
//   when it lies below the count or the store has wrapped since the clear,
//   so no clearing sweep is needed.
//   Reset: CRC and history go to FFFF, count and wrapped flag to zero, the
//   store reads as empty, no result is pending. s_ready is low during reset
//   and high from the first cycle after it.
//   Stall: while m_ready is low a pending result holds and s_ready is low,
//   so state does not advance until the result transfer completes.
module rx_byte_buffer_with_crc16_history_top
    import rxbb_pkg::*;
#(
    parameter int STORE_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [7:0]  s_rx_byte,
    input  logic [7:0]  s_read_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_crc_now,
    output logic [15:0] m_crc_back1,
    output logic [15:0] m_crc_back2,
    output logic [15:0] m_crc_back3,
    output logic [15:0] m_crc_back4,
    output logic [8:0]  m_byte_count,
    output logic        m_store_wrapped,
    output logic [7:0]  m_read_data
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int IW = (CW > 8) ? CW : 8;

    op_t           op;
    logic          accept;
    logic          is_full;

    logic          m_valid_reg,  m_valid_next;
    crc_t          crc_reg,      crc_next;
    crc_t          hist_reg  [HIST_N];
    crc_t          hist_next [HIST_N];
    logic [CW-1:0] count_reg,    count_next;
    logic          wrap_reg,     wrap_next;
    logic          full_reg,     full_next;
    logic          rd_ok_reg,    rd_ok_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    rd_data;

    assign op      = op_t'(s_operation);
    assign s_ready = aresetn && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign is_full = (count_reg >= CW'(STORE_DEPTH));

    always_comb begin
        m_valid_next = m_valid_reg;
        crc_next     = crc_reg;
        hist_next    = hist_reg;
        count_next   = count_reg;
        wrap_next    = wrap_reg;
        full_next    = full_reg;
        rd_ok_next   = rd_ok_reg;
        wr_en        = 1'b0;
        wr_addr      = AW'(count_reg);
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            m_valid_next = 1'b1;
            rd_ok_next   = 1'b0;
            case (op)
                OP_RECEIVE: begin
                    wr_en = 1'b1;
                    if (is_full) begin
                        wr_addr    = '0;
                        count_next = CW'(1);
                        wrap_next  = 1'b1;
                        full_next  = 1'b1;
                    end else begin
                        count_next = count_reg + CW'(1);
                    end
                    for (int k = HIST_N - 1; k > 0; k--) begin
                        hist_next[k] = hist_reg[k-1];
                    end
                    hist_next[0] = crc_reg;
                    crc_next     = crc16_byte(crc_reg, s_rx_byte);
                end
                OP_READ: begin
                    rd_ok_next = (IW'(s_read_index) < IW'(STORE_DEPTH)) &&
                                 (full_reg || (IW'(s_read_index) < IW'(count_reg)));
                end
                OP_CLEAR: begin
                    count_next = '0;
                    full_next  = 1'b0;
                end
                OP_RESTART: begin
                    crc_next = CRC_INIT;
                    for (int k = 0; k < HIST_N; k++) begin
                        hist_next[k] = CRC_INIT;
                    end
                end
                default: begin
                    rd_ok_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            crc_reg     <= CRC_INIT;
            for (int k = 0; k < HIST_N; k++) begin
                hist_reg[k] <= CRC_INIT;
            end
            count_reg   <= '0;
            wrap_reg    <= 1'b0;
            full_reg    <= 1'b0;
            rd_ok_reg   <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            crc_reg     <= crc_next;
            hist_reg    <= hist_next;
            count_reg   <= count_next;
            wrap_reg    <= wrap_next;
            full_reg    <= full_next;
            rd_ok_reg   <= rd_ok_next;
        end
    end

    rxbb_store #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (accept && wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_rx_byte),
        .rd_en   (accept && (op == OP_READ)),
        .rd_addr (AW'(s_read_index)),
        .rd_data (rd_data)
    );

    assign m_valid         = m_valid_reg;
    assign m_crc_now       = crc_reg;
    assign m_crc_back1     = hist_reg[0];
    assign m_crc_back2     = hist_reg[1];
    assign m_crc_back3     = hist_reg[2];
    assign m_crc_back4     = hist_reg[3];
    assign m_byte_count    = COUNT_OW'(count_reg);
    assign m_store_wrapped = wrap_reg;
    assign m_read_data     = rd_ok_reg ? rd_data : 8'h00;

endmodule

[tb/rx_byte_buffer_with_crc16_history_top_tb.sv]
// Testbench for the receive byte buffer with CRC-16/MODBUS history: directed and random traffic, scoreboard.
module rx_byte_buffer_with_crc16_history_top_tb;
    import rxbb_pkg::*;

    localparam int STORE_DEPTH = 256;
    localparam int ITEM_TARGET = 1250;
    localparam int CALM_AFTER  = 1100;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [15:0] crc_now;
        logic [15:0] crc_back1;
        logic [15:0] crc_back2;
        logic [15:0] crc_back3;
        logic [15:0] crc_back4;
        logic [8:0]  byte_count;
        logic        store_wrapped;
        logic [7:0]  read_data;
    } rx_result_t;

    class rxbuf_scoreboard;
        logic [15:0] crc_lut [256];
        logic [15:0] crc_reg;
        logic [15:0] crc_hist [HIST_N];
        logic [7:0]  stored [STORE_DEPTH];
        int unsigned fill;
        bit          wrapped;
        rx_result_t  awaited_results [$];
        int unsigned errors;

        function new();
            logic [15:0] c;
            for (int i = 0; i < 256; i++) begin
                c = 16'(i);
                for (int k = 0; k < 8; k++) begin
                    if (c[0]) begin
                        c = (c >> 1) ^ CRC_POLY;
                    end else begin
                        c = c >> 1;
                    end
                end
                crc_lut[i] = c;
            end
            foreach (stored[i]) stored[i] = 8'h00;
            fill    = 0;
            wrapped = 1'b0;
            errors  = 0;
            restart_crc();
        endfunction

        function void restart_crc();
            crc_reg = CRC_INIT;
            foreach (crc_hist[k]) crc_hist[k] = CRC_INIT;
        endfunction

        // Advance the state by one accepted input transfer and queue its result.
        function void take_item(op_t op, logic [7:0] rx, logic [7:0] idx);
            rx_result_t r;
            r.read_data = 8'h00;
            case (op)
                OP_RECEIVE: begin
                    if (fill >= STORE_DEPTH) begin
                        fill    = 0;
                        wrapped = 1'b1;
                    end
                    stored[fill] = rx;
                    for (int k = HIST_N - 1; k > 0; k--) crc_hist[k] = crc_hist[k-1];
                    crc_hist[0] = crc_reg;
                    crc_reg = (crc_reg >> 8) ^ crc_lut[crc_reg[7:0] ^ rx];
                    fill++;
                end
                OP_READ: begin
                    if (idx < STORE_DEPTH) r.read_data = stored[idx];
                end
                OP_CLEAR: begin
                    foreach (stored[i]) stored[i] = 8'h00;
                    fill = 0;
                end
                default: restart_crc();
            endcase
            r.crc_now       = crc_reg;
            r.crc_back1     = crc_hist[0];
            r.crc_back2     = crc_hist[1];
            r.crc_back3     = crc_hist[2];
            r.crc_back4     = crc_hist[3];
            r.byte_count    = fill[8:0];
            r.store_wrapped = wrapped;
            awaited_results.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(rx_result_t got);
            rx_result_t want;
            if (awaited_results.size() == 0) begin
                $error("result transfer with no item outstanding");
                errors++;
                return;
            end
            want = awaited_results.pop_front();
            compare_field("crc_now", want.crc_now, got.crc_now);
            compare_field("crc_back1", want.crc_back1, got.crc_back1);
            compare_field("crc_back2", want.crc_back2, got.crc_back2);
            compare_field("crc_back3", want.crc_back3, got.crc_back3);
            compare_field("crc_back4", want.crc_back4, got.crc_back4);
            compare_field("byte_count", want.byte_count, got.byte_count);
            compare_field("store_wrapped", want.store_wrapped, got.store_wrapped);
            compare_field("read_data", want.read_data, got.read_data);
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_operation = OP_READ;
    logic [7:0]  s_rx_byte = 8'h00;
    logic [7:0]  s_read_index = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_crc_now;
    logic [15:0] m_crc_back1;
    logic [15:0] m_crc_back2;
    logic [15:0] m_crc_back3;
    logic [15:0] m_crc_back4;
    logic [8:0]  m_byte_count;
    logic        m_store_wrapped;
    logic [7:0]  m_read_data;

    rxbuf_scoreboard sb;
    int unsigned     sent = 0;
    int unsigned     cycles = 0;
    int unsigned     stall_left = 0;
    bit              calm = 1'b0;

    rx_byte_buffer_with_crc16_history_top #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_rx_byte       (s_rx_byte),
        .s_read_index    (s_read_index),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_crc_now       (m_crc_now),
        .m_crc_back1     (m_crc_back1),
        .m_crc_back2     (m_crc_back2),
        .m_crc_back3     (m_crc_back3),
        .m_crc_back4     (m_crc_back4),
        .m_byte_count    (m_byte_count),
        .m_store_wrapped (m_store_wrapped),
        .m_read_data     (m_read_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** rx_byte_buffer_with_crc16_history_top: FAILED **");
            $finish;
        end
    end

    // result side backpressure in random bursts
    always @(negedge aclk) begin
        if (calm || !aresetn) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 3);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(rx_result_t'{m_crc_now, m_crc_back1, m_crc_back2, m_crc_back3,
                                         m_crc_back4, m_byte_count, m_store_wrapped,
                                         m_read_data});
        end
    end

    task automatic send_op(op_t op, logic [7:0] rx, logic [7:0] idx);
        int gap;
        @(negedge aclk);
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 4);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_operation  <= op;
        s_rx_byte    <= rx;
        s_read_index <= idx;
        do @(posedge aclk); while (!s_ready);
        sb.take_item(op, rx, idx);
        sent++;
        if (sent >= CALM_AFTER) calm = 1'b1;
    endtask

    // half the time an entry that holds a received byte, otherwise any entry
    function automatic logic [7:0] pick_index();
        if (sb.fill > 0 && $urandom_range(0, 1) == 0) return 8'($urandom_range(0, sb.fill - 1));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.awaited_results.size() != 0) @(posedge aclk);
    endtask

    initial begin
        int  len;
        int  kind;
        bit  wrap_done;
        sb = new();
        wrap_done = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: reset contents, byte extremes, full history shift, restart, clear
        send_op(OP_READ, 8'h00, 8'h00);
        send_op(OP_READ, 8'hFF, 8'hFF);
        send_op(OP_RECEIVE, 8'h00, 8'h00);
        send_op(OP_RECEIVE, 8'hFF, 8'hFF);
        send_op(OP_RECEIVE, 8'hA5, 8'h5A);
        send_op(OP_RECEIVE, 8'h5A, 8'hA5);
        send_op(OP_RECEIVE, 8'h01, 8'h80);
        send_op(OP_READ, 8'h00, 8'h00);
        send_op(OP_READ, 8'h00, 8'h04);
        send_op(OP_READ, 8'h00, 8'hFF);
        send_op(OP_RESTART, 8'hFF, 8'hFF);
        send_op(OP_RECEIVE, 8'h80, 8'h01);
        send_op(OP_CLEAR, 8'hFF, 8'hFF);
        send_op(OP_READ, 8'h00, 8'h00);
        send_op(OP_READ, 8'h00, 8'h01);
        send_op(OP_RECEIVE, 8'h7F, 8'hFE);
        send_op(OP_READ, 8'h00, 8'h00);

        while (sent < ITEM_TARGET) begin
            if (!wrap_done && sent >= 350) begin
                // long frame with no clear: fills the store and wraps it
                for (int n = 0; n < 280; n++) begin
                    send_op(OP_RECEIVE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                    if (n % 8 == 7) send_op(OP_READ, 8'($urandom_range(0, 255)), pick_index());
                end
                for (int n = 0; n < 10; n++) begin
                    send_op(OP_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                end
                wrap_done = 1'b1;
                drain();
                continue;
            end
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                len = $urandom_range(1, 40);
                for (int n = 0; n < len; n++) begin
                    send_op(OP_RECEIVE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                    if ($urandom_range(0, 4) == 0) begin
                        send_op(OP_READ, 8'($urandom_range(0, 255)), pick_index());
                    end
                end
                case ($urandom_range(0, 6))
                    0, 1: send_op(OP_RESTART, 8'($urandom_range(0, 255)),
                                  8'($urandom_range(0, 255)));
                    2: send_op(OP_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                    default: ;
                endcase
            end else begin
                len = $urandom_range(1, 5);
                for (int n = 0; n < len; n++) begin
                    send_op(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)));
                end
            end
        end

        drain();
        repeat (4) @(posedge aclk);
        if (sb.errors == 0 && sb.awaited_results.size() == 0) begin
            $display("** rx_byte_buffer_with_crc16_history_top: PASSED **");
        end else begin
            $display("** rx_byte_buffer_with_crc16_history_top: FAILED **");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/rxbb_pkg.sv
rtl/rxbb_store.sv
rtl/rx_byte_buffer_with_crc16_history_top.sv
tb/rx_byte_buffer_with_crc16_history_top_tb.sv
